// ===== design/rpvs_pkg.sv =====
// Shared types, constants and the arctangent table for the ramped phasor source.
// No dependencies; every other design file but rpvs_div refers to it by scoped names.
`default_nettype none

package rpvs_pkg;

    // angle datapath width (Q3.29 with headroom for sums)
    localparam int ANGLE_W = 36;
    // CORDIC data widths for the fade pass and the phasor passes
    localparam int COS_W   = 34;
    localparam int VEC_W   = 54;
    // width of the angle offset before modulo reduction, and floor(2^60 / TWO_PI_U)
    // used to estimate the quotient from the top 32 offset bits
    localparam int OFF_W           = 60;
    localparam logic [28:0] MOD_RECIP = 29'd341782637;

    localparam logic signed [ANGLE_W-1:0] HALF_PI = 36'sd843314857;
    localparam logic signed [ANGLE_W-1:0] PI      = 36'sd1686629713;
    localparam logic signed [ANGLE_W-1:0] TWO_PI  = 36'sd3373259426;
    localparam logic [31:0] PI_U     = 32'd1686629713;
    localparam logic [31:0] TWO_PI_U = 32'd3373259426;
    localparam logic [31:0] INV_K    = 32'd2608131496;

    typedef enum logic [1:0] {
        REGION_BEFORE = 2'd0,
        REGION_RAMP   = 2'd1,
        REGION_AFTER  = 2'd2
    } region_t;

    // configuration register indexes
    localparam logic [2:0] REG_REF_REAL    = 3'd0;
    localparam logic [2:0] REG_REF_IMAG    = 3'd1;
    localparam logic [2:0] REG_STEP_REAL   = 3'd2;
    localparam logic [2:0] REG_STEP_IMAG   = 3'd3;
    localparam logic [2:0] REG_EXTRA_RATE  = 3'd4;
    localparam logic [2:0] REG_SWITCH_TIME = 3'd5;
    localparam logic [2:0] REG_RAMP_LENGTH = 3'd6;

    // atan(2^-i) in Q3.29
    function automatic logic signed [ANGLE_W-1:0] atan_q29(input logic [4:0] idx);
        case (idx)
            5'd0:    return 36'sd421657428;
            5'd1:    return 36'sd248918915;
            5'd2:    return 36'sd131521918;
            5'd3:    return 36'sd66762579;
            5'd4:    return 36'sd33510843;
            5'd5:    return 36'sd16771758;
            5'd6:    return 36'sd8387925;
            5'd7:    return 36'sd4194219;
            5'd8:    return 36'sd2097141;
            5'd9:    return 36'sd1048575;
            5'd10:   return 36'sd524288;
            5'd11:   return 36'sd262144;
            5'd12:   return 36'sd131072;
            5'd13:   return 36'sd65536;
            5'd14:   return 36'sd32768;
            5'd15:   return 36'sd16384;
            5'd16:   return 36'sd8192;
            5'd17:   return 36'sd4096;
            5'd18:   return 36'sd2048;
            5'd19:   return 36'sd1024;
            5'd20:   return 36'sd512;
            5'd21:   return 36'sd256;
            5'd22:   return 36'sd128;
            5'd23:   return 36'sd64;
            5'd24:   return 36'sd32;
            5'd25:   return 36'sd16;
            5'd26:   return 36'sd8;
            5'd27:   return 36'sd4;
            5'd28:   return 36'sd2;
            5'd29:   return 36'sd1;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== design/rpvs_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
// Depends on nothing but the clock enable supplied by the top level.
`default_nettype none

module rpvs_div #(
    parameter int QW = 32,
    parameter int DW = 48,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire logic [DW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_vld,
    output logic [QW-1:0]      quo,
    output logic [SW-1:0]      out_side
);

    logic          vld_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [SW-1:0] side_reg [QW];

    logic          vld_in  [QW];
    logic [DW-1:0] rem_in  [QW];
    logic [QW-1:0] q_in    [QW];
    logic [SW-1:0] side_in [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [DW:0]   r2;
            logic          ge;
            logic [DW:0]   diff;

            // chain each stage to the one before it
            if (k == 0)
            begin : g_first
                assign vld_in[k]  = in_vld;
                assign rem_in[k]  = num;
                assign q_in[k]    = '0;
                assign side_in[k] = in_side;
            end
            else
            begin : g_next
                assign vld_in[k]  = vld_reg[k-1];
                assign rem_in[k]  = rem_reg[k-1];
                assign q_in[k]    = q_reg[k-1];
                assign side_in[k] = side_reg[k-1];
            end

            // shift in one bit, subtract the divisor where it fits
            assign r2   = {rem_in[k], 1'b0};
            assign ge   = (r2 >= {1'b0, den});
            assign diff = r2 - {1'b0, den};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
                    q_reg[k]    <= {q_in[k][QW-2:0], ge};
                    side_reg[k] <= side_in[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QW-1];
    assign quo      = q_reg[QW-1];
    assign out_side = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== design/rpvs_mod.sv =====
// Pipelined reduction of the angle offset modulo 2*pi by reciprocal multiplication, four stages.
// Uses the width, reciprocal and modulus constants of rpvs_pkg.
`default_nettype none

module rpvs_mod #(
    parameter int SW = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [rpvs_pkg::OFF_W-1:0]  in_val,
    input  wire logic [SW-1:0]               in_side,
    output logic                             out_vld,
    output logic [31:0]                      residue,
    output logic [SW-1:0]                    out_side
);

    localparam int NW = rpvs_pkg::OFF_W;
    localparam int RW = 35;
    localparam logic [RW-1:0] MOD1 = RW'(rpvs_pkg::TWO_PI_U);
    localparam logic [RW-1:0] MOD2 = MOD1 << 1;

    logic          a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic [SW-1:0] a_side_reg, b_side_reg, c_side_reg, d_side_reg;
    logic [RW-1:0] a_low_reg, b_low_reg;
    logic [28:0]   a_q_reg;
    logic [RW-1:0] b_qm_reg;
    logic [RW-1:0] c_rem_reg;
    logic [31:0]   d_res_reg;

    logic [60:0]   est_prod;
    logic [60:0]   qm_prod;
    logic [RW-1:0] r_sub1, r_sub2;

    // estimate the quotient from the top bits; it is low by at most two
    assign est_prod = 61'(in_val[NW-1:28]) * 61'(rpvs_pkg::MOD_RECIP);
    assign qm_prod  = 61'(a_q_reg) * 61'(rpvs_pkg::TWO_PI_U);
    assign r_sub1   = c_rem_reg - MOD1;
    assign r_sub2   = c_rem_reg - MOD2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    // estimate, multiply back, subtract, then drop the modulus where it still fits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_q_reg    <= est_prod[60:32];
            a_low_reg  <= in_val[RW-1:0];
            a_side_reg <= in_side;

            b_qm_reg   <= qm_prod[RW-1:0];
            b_low_reg  <= a_low_reg;
            b_side_reg <= a_side_reg;

            c_rem_reg  <= b_low_reg - b_qm_reg;
            c_side_reg <= b_side_reg;

            if (c_rem_reg >= MOD2)
            begin
                d_res_reg <= r_sub2[31:0];
            end
            else if (c_rem_reg >= MOD1)
            begin
                d_res_reg <= r_sub1[31:0];
            end
            else
            begin
                d_res_reg <= c_rem_reg[31:0];
            end
            d_side_reg <= c_side_reg;
        end
    end

    assign out_vld  = d_vld_reg;
    assign residue  = d_res_reg;
    assign out_side = d_side_reg;

endmodule

`default_nettype wire

// ===== design/rpvs_cordic.sv =====
// Pipelined CORDIC (rotation or vectoring) with quadrant pre-rotation and 1/K scaling.
// Uses the angle constants and arctangent table of rpvs_pkg.
`default_nettype none

module rpvs_cordic #(
    parameter int W      = 54,
    parameter int STEPS  = 16,
    parameter bit VECTOR = 1'b0,
    parameter int SW     = 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_vld,
    input  wire logic signed [W-1:0]                 in_x,
    input  wire logic signed [W-1:0]                 in_y,
    input  wire logic signed [rpvs_pkg::ANGLE_W-1:0] in_z,
    input  wire logic [SW-1:0]                       in_side,
    output logic                                     out_vld,
    output logic signed [W-1:0]                      out_x,
    output logic signed [W-1:0]                      out_y,
    output logic signed [rpvs_pkg::ANGLE_W-1:0]      out_z,
    output logic [SW-1:0]                            out_side
);

    localparam int ZW = rpvs_pkg::ANGLE_W;

    // quadrant pre-rotation
    logic signed [W-1:0]  pre_x, pre_y;
    logic signed [ZW-1:0] pre_z;

    always_comb
    begin
        pre_x = in_x;
        pre_y = in_y;
        pre_z = VECTOR ? '0 : in_z;
        if (VECTOR)
        begin
            if (in_x[W-1])
            begin
                if (!in_y[W-1])
                begin
                    pre_x = in_y;
                    pre_y = -in_x;
                    pre_z = rpvs_pkg::HALF_PI;
                end
                else
                begin
                    pre_x = -in_y;
                    pre_y = in_x;
                    pre_z = -rpvs_pkg::HALF_PI;
                end
            end
        end
        else
        begin
            if (in_z > rpvs_pkg::HALF_PI)
            begin
                pre_x = -in_y;
                pre_y = in_x;
                pre_z = in_z - rpvs_pkg::HALF_PI;
            end
            else if (in_z < -rpvs_pkg::HALF_PI)
            begin
                pre_x = in_y;
                pre_y = -in_x;
                pre_z = in_z + rpvs_pkg::HALF_PI;
            end
        end
    end

    logic                 vld0_reg;
    logic signed [W-1:0]  x0_reg, y0_reg;
    logic signed [ZW-1:0] z0_reg;
    logic [SW-1:0]        side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= pre_x;
            y0_reg    <= pre_y;
            z0_reg    <= pre_z;
            side0_reg <= in_side;
        end
    end

    // micro-rotation stages
    logic                 vld_reg  [STEPS];
    logic signed [W-1:0]  x_reg    [STEPS];
    logic signed [W-1:0]  y_reg    [STEPS];
    logic signed [ZW-1:0] z_reg    [STEPS];
    logic [SW-1:0]        side_reg [STEPS];

    logic                 vld_in  [STEPS];
    logic signed [W-1:0]  x_in    [STEPS];
    logic signed [W-1:0]  y_in    [STEPS];
    logic signed [ZW-1:0] z_in    [STEPS];
    logic [SW-1:0]        side_in [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_iter
            logic signed [W-1:0]  dx, dy;
            logic signed [ZW-1:0] at;
            logic                 ccw;

            if (k == 0)
            begin : g_first
                assign vld_in[k]  = vld0_reg;
                assign x_in[k]    = x0_reg;
                assign y_in[k]    = y0_reg;
                assign z_in[k]    = z0_reg;
                assign side_in[k] = side0_reg;
            end
            else
            begin : g_next
                assign vld_in[k]  = vld_reg[k-1];
                assign x_in[k]    = x_reg[k-1];
                assign y_in[k]    = y_reg[k-1];
                assign z_in[k]    = z_reg[k-1];
                assign side_in[k] = side_reg[k-1];
            end

            assign dx  = y_in[k] >>> k;
            assign dy  = x_in[k] >>> k;
            assign at  = rpvs_pkg::atan_q29(5'(k));
            // vectoring drives y to zero, rotation drives z to zero
            assign ccw = VECTOR ? y_in[k][W-1] : !z_in[k][ZW-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= ccw ? (x_in[k] - dx) : (x_in[k] + dx);
                    y_reg[k]    <= ccw ? (y_in[k] + dy) : (y_in[k] - dy);
                    z_reg[k]    <= ccw ? (z_in[k] - at) : (z_in[k] + at);
                    side_reg[k] <= side_in[k];
                end
            end
        end
    endgenerate

    // gain compensation: magnitude, two partial products, sum and sign
    logic                 k1_vld_reg, k2_vld_reg, k3_vld_reg;
    logic [W-1:0]         k1_ux_reg, k1_uy_reg;
    logic                 k1_nx_reg, k1_ny_reg, k2_nx_reg, k2_ny_reg;
    logic signed [ZW-1:0] k1_z_reg, k2_z_reg, k3_z_reg;
    logic [SW-1:0]        k1_side_reg, k2_side_reg, k3_side_reg;
    logic [W-1:0]         k2_hx_reg, k2_hy_reg;
    logic [63:0]          k2_lx_reg, k2_ly_reg;
    logic signed [W-1:0]  k3_x_reg, k3_y_reg;

    logic signed [W-1:0]  xl, yl;
    logic [W-1:0]         sum_x, sum_y;

    assign xl    = x_reg[STEPS-1];
    assign yl    = y_reg[STEPS-1];
    assign sum_x = k2_hx_reg + W'(k2_lx_reg[63:32]);
    assign sum_y = k2_hy_reg + W'(k2_ly_reg[63:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_vld_reg <= 1'b0;
            k2_vld_reg <= 1'b0;
            k3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            k1_vld_reg <= vld_reg[STEPS-1];
            k2_vld_reg <= k1_vld_reg;
            k3_vld_reg <= k2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_ux_reg   <= xl[W-1] ? W'(-xl) : W'(xl);
            k1_uy_reg   <= yl[W-1] ? W'(-yl) : W'(yl);
            k1_nx_reg   <= xl[W-1];
            k1_ny_reg   <= yl[W-1];
            k1_z_reg    <= z_reg[STEPS-1];
            k1_side_reg <= side_reg[STEPS-1];

            k2_hx_reg   <= W'(k1_ux_reg[W-1:32]) * W'(rpvs_pkg::INV_K);
            k2_hy_reg   <= W'(k1_uy_reg[W-1:32]) * W'(rpvs_pkg::INV_K);
            k2_lx_reg   <= 64'(k1_ux_reg[31:0]) * 64'(rpvs_pkg::INV_K);
            k2_ly_reg   <= 64'(k1_uy_reg[31:0]) * 64'(rpvs_pkg::INV_K);
            k2_nx_reg   <= k1_nx_reg;
            k2_ny_reg   <= k1_ny_reg;
            k2_z_reg    <= k1_z_reg;
            k2_side_reg <= k1_side_reg;

            k3_x_reg    <= k2_nx_reg ? -$signed(sum_x) : $signed(sum_x);
            k3_y_reg    <= k2_ny_reg ? -$signed(sum_y) : $signed(sum_y);
            k3_z_reg    <= k2_z_reg;
            k3_side_reg <= k2_side_reg;
        end
    end

    assign out_vld  = k3_vld_reg;
    assign out_x    = k3_x_reg;
    assign out_y    = k3_y_reg;
    assign out_z    = k3_z_reg;
    assign out_side = k3_side_reg;

endmodule

`default_nettype wire

// ===== design/ramped_phasor_voltage_source_unit.sv =====
// Top level of the ramped phasor voltage source: config registers and the full pipeline.
// Depends on rpvs_pkg, rpvs_div, rpvs_cordic and rpvs_mod.
//
// channel   direction  handshake               payload
// s_*       in         s_tvalid / s_tready     s_tdata[47:0] sim_time
// m_*       out        m_tvalid / m_tready     m_tdata out_real, out_imag; m_tuser region
// cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One time sample enters per cycle while the output is not stalled; the pipe is built from
// the 32-stage divider, the three CORDIC passes and the four-stage modulo reduction.
// All stages advance together on one enable; a stalled output holds the whole pipe,
// nothing is lost or repeated. cfg_ready is always high.
// Reset clears valid bits and all configuration registers to zero.
`default_nettype none

module ramped_phasor_voltage_source_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [47:0] sim_time
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] out_real, [63:32] out_imag
    output logic [1:0]       m_tuser,   // [1:0] region
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int ZW = rpvs_pkg::ANGLE_W;
    localparam int CW = rpvs_pkg::COS_W;
    localparam int VW = rpvs_pkg::VEC_W;

    typedef struct packed {
        logic [47:0]       t;
        rpvs_pkg::region_t region;
    } div_side_t;

    typedef struct packed {
        logic [47:0]       t;
        rpvs_pkg::region_t region;
        logic [33:0]       px;
        logic [33:0]       py;
    } cos_side_t;

    typedef struct packed {
        logic [47:0]       t;
        rpvs_pkg::region_t region;
        logic [30:0]       fade;
    } vec_side_t;

    typedef struct packed {
        logic [VW-1:0]     mag;
        logic [ZW-1:0]     ang;
        rpvs_pkg::region_t region;
        logic              wneg;
    } mod_side_t;

    typedef struct packed {
        rpvs_pkg::region_t region;
    } rot_side_t;

    // ---------------------------------------------------------------
    // configuration registers
    logic [31:0] ref_real_reg, ref_imag_reg, step_real_reg, step_imag_reg, rate_reg;
    logic [47:0] switch_reg, ramp_reg;

    assign cfg_ready = 1'b1;

    // write one register per transaction, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_real_reg  <= '0;
            ref_imag_reg  <= '0;
            step_real_reg <= '0;
            step_imag_reg <= '0;
            rate_reg      <= '0;
            switch_reg    <= '0;
            ramp_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpvs_pkg::REG_REF_REAL:    ref_real_reg  <= cfg_data[31:0];
                rpvs_pkg::REG_REF_IMAG:    ref_imag_reg  <= cfg_data[31:0];
                rpvs_pkg::REG_STEP_REAL:   step_real_reg <= cfg_data[31:0];
                rpvs_pkg::REG_STEP_IMAG:   step_imag_reg <= cfg_data[31:0];
                rpvs_pkg::REG_EXTRA_RATE:  rate_reg      <= cfg_data[31:0];
                rpvs_pkg::REG_SWITCH_TIME: switch_reg    <= cfg_data;
                rpvs_pkg::REG_RAMP_LENGTH: ramp_reg      <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // global advance: the pipe moves unless the output holds an untaken result
    logic advance;
    logic out_vld_reg;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;

    // ---------------------------------------------------------------
    // stage 0: classify the time and form the ramp numerator
    logic              s0_vld_reg;
    div_side_t         s0_side_reg;
    logic [47:0]       s0_rem_reg;
    logic [48:0]       ramp_end;
    rpvs_pkg::region_t s0_region;

    assign ramp_end = {1'b0, switch_reg} + {1'b0, ramp_reg};

    always_comb
    begin
        if (s_tdata < switch_reg)
        begin
            s0_region = rpvs_pkg::REGION_BEFORE;
        end
        else if ({1'b0, s_tdata} < ramp_end)
        begin
            s0_region = rpvs_pkg::REGION_RAMP;
        end
        else
        begin
            s0_region = rpvs_pkg::REGION_AFTER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_side_reg.t      <= s_tdata;
            s0_side_reg.region <= s0_region;
            s0_rem_reg         <= s_tdata - switch_reg;
        end
    end

    // ---------------------------------------------------------------
    // ramp fraction f = (t - ts) / tr
    logic        d_vld;
    logic [31:0] d_f;
    div_side_t   d_side;

    rpvs_div #(
        .QW (32),
        .DW (48),
        .SW ($bits(div_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (s0_vld_reg),
        .num      (s0_rem_reg),
        .den      (ramp_reg),
        .in_side  (s0_side_reg),
        .out_vld  (d_vld),
        .quo      (d_f),
        .out_side (d_side)
    );

    // ---------------------------------------------------------------
    // stage 1: products of f with pi and the step components
    logic        s1_vld_reg;
    div_side_t   s1_side_reg;
    logic [63:0] s1_pi_reg, s1_pr_reg, s1_pi_im_reg;
    logic [31:0] step_real_mag, step_imag_mag;

    assign step_real_mag = step_real_reg[31] ? (~step_real_reg + 32'd1) : step_real_reg;
    assign step_imag_mag = step_imag_reg[31] ? (~step_imag_reg + 32'd1) : step_imag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_side_reg  <= d_side;
            s1_pi_reg    <= 64'(rpvs_pkg::PI_U) * 64'(d_f);
            s1_pr_reg    <= 64'(step_real_mag) * 64'(d_f);
            s1_pi_im_reg <= 64'(step_imag_mag) * 64'(d_f);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: round f*step (the full step after the ramp), add the reference, form the fade angle
    logic               s2_vld_reg;
    cos_side_t          s2_side_reg;
    logic [31:0]        s2_theta_reg;
    logic [64:0]        rnd_r_sum, rnd_i_sum;
    logic signed [33:0] term_r, term_i, px_next, py_next;
    logic signed [33:0] ref_r_ext, ref_i_ext;

    assign rnd_r_sum = {1'b0, s1_pr_reg} + 65'h0_8000_0000;
    assign rnd_i_sum = {1'b0, s1_pi_im_reg} + 65'h0_8000_0000;
    assign term_r    = step_real_reg[31] ? -$signed({1'b0, rnd_r_sum[64:32]})
                                         :  $signed({1'b0, rnd_r_sum[64:32]});
    assign term_i    = step_imag_reg[31] ? -$signed({1'b0, rnd_i_sum[64:32]})
                                         :  $signed({1'b0, rnd_i_sum[64:32]});
    assign ref_r_ext = 34'($signed(ref_real_reg));
    assign ref_i_ext = 34'($signed(ref_imag_reg));

    always_comb
    begin
        if (s1_side_reg.region == rpvs_pkg::REGION_AFTER)
        begin
            px_next = ref_r_ext + 34'($signed(step_real_reg));
            py_next = ref_i_ext + 34'($signed(step_imag_reg));
        end
        else
        begin
            px_next = ref_r_ext + term_r;
            py_next = ref_i_ext + term_i;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_side_reg.t      <= s1_side_reg.t;
            s2_side_reg.region <= s1_side_reg.region;
            s2_side_reg.px     <= px_next;
            s2_side_reg.py     <= py_next;
            s2_theta_reg       <= s1_pi_reg[63:32];
        end
    end

    // ---------------------------------------------------------------
    // cos(pi*f) by rotating (2^30, 0)
    logic                 c_vld;
    logic signed [CW-1:0] c_x, c_y;
    logic signed [ZW-1:0] c_z;
    cos_side_t            c_side;

    rpvs_cordic #(
        .W      (CW),
        .STEPS  (CORDIC_STEPS),
        .VECTOR (1'b0),
        .SW     ($bits(cos_side_t))
    ) u_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (s2_vld_reg),
        .in_x     (CW'(34'sd1073741824)),
        .in_y     ('0),
        .in_z     ($signed({4'b0, s2_theta_reg})),
        .in_side  (s2_side_reg),
        .out_vld  (c_vld),
        .out_x    (c_x),
        .out_y    (c_y),
        .out_z    (c_z),
        .out_side (c_side)
    );

    // ---------------------------------------------------------------
    // stage 3: raised-cosine fade, clamped to [0, 1]
    logic               s3_vld_reg;
    vec_side_t          s3_side_reg;
    logic [33:0]        s3_px_reg, s3_py_reg;
    logic signed [34:0] fade_tmp;
    logic [34:0]        fade_pos, fade_half;
    logic [30:0]        fade_next;

    assign fade_tmp  = 35'sd1073741824 - 35'(c_x);
    assign fade_pos  = fade_tmp[34] ? '0 : fade_tmp;
    assign fade_half = (fade_pos + 35'd1) >> 1;

    always_comb
    begin
        if (c_side.region == rpvs_pkg::REGION_AFTER || fade_half > 35'd1073741824)
        begin
            fade_next = 31'd1073741824;
        end
        else
        begin
            fade_next = fade_half[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_vld_reg <= c_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_side_reg.t      <= c_side.t;
            s3_side_reg.region <= c_side.region;
            s3_side_reg.fade   <= fade_next;
            s3_px_reg          <= c_side.px;
            s3_py_reg          <= c_side.py;
        end
    end

    // ---------------------------------------------------------------
    // magnitude and angle of the phasor, with 16 guard bits
    logic                 v_vld;
    logic signed [VW-1:0] v_x, v_y;
    logic signed [ZW-1:0] v_z;
    vec_side_t            v_side;

    rpvs_cordic #(
        .W      (VW),
        .STEPS  (CORDIC_STEPS),
        .VECTOR (1'b1),
        .SW     ($bits(vec_side_t))
    ) u_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (s3_vld_reg),
        .in_x     ($signed({{4{s3_px_reg[33]}}, s3_px_reg, 16'b0})),
        .in_y     ($signed({{4{s3_py_reg[33]}}, s3_py_reg, 16'b0})),
        .in_z     ('0),
        .in_side  (s3_side_reg),
        .out_vld  (v_vld),
        .out_x    (v_x),
        .out_y    (v_y),
        .out_z    (v_z),
        .out_side (v_side)
    );

    // ---------------------------------------------------------------
    // stages 4-6: offset = |rate| * fade * t / 2^49
    logic        s4_vld_reg, s5_vld_reg, s6_vld_reg;
    mod_side_t   s4_side_reg, s5_side_reg, s6_side_reg;
    logic [62:0] s4_a_reg;
    logic [47:0] s4_t_reg;
    logic [31:0] rate_mag;
    logic [63:0] s5_p0_reg;
    logic [47:0] s5_p1_reg;
    logic [62:0] s5_p2_reg;
    logic [46:0] s5_p3_reg;
    logic [109:0] off_full;
    logic [rpvs_pkg::OFF_W-1:0] s6_off_reg;

    assign rate_mag = rate_reg[31] ? (~rate_reg + 32'd1) : rate_reg;
    assign off_full = 110'(s5_p0_reg) + (110'(s5_p1_reg) << 32) + (110'(s5_p2_reg) << 32)
                    + (110'(s5_p3_reg) << 64);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_vld_reg <= v_vld;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_a_reg           <= 63'(rate_mag) * 63'(v_side.fade);
            s4_t_reg           <= v_side.t;
            s4_side_reg.mag    <= v_x;
            s4_side_reg.ang    <= v_z;
            s4_side_reg.region <= v_side.region;
            s4_side_reg.wneg   <= rate_reg[31];

            s5_p0_reg   <= 64'(s4_a_reg[31:0]) * 64'(s4_t_reg[31:0]);
            s5_p1_reg   <= 48'(s4_a_reg[31:0]) * 48'(s4_t_reg[47:32]);
            s5_p2_reg   <= 63'(s4_a_reg[62:32]) * 63'(s4_t_reg[31:0]);
            s5_p3_reg   <= 47'(s4_a_reg[62:32]) * 47'(s4_t_reg[47:32]);
            s5_side_reg <= s4_side_reg;

            s6_off_reg  <= off_full[108:49];
            s6_side_reg <= s5_side_reg;
        end
    end

    // ---------------------------------------------------------------
    // offset modulo 2*pi
    logic        m_vld;
    logic [31:0] m_res;
    mod_side_t   m_side;

    rpvs_mod #(
        .SW ($bits(mod_side_t))
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (s6_vld_reg),
        .in_val   (s6_off_reg),
        .in_side  (s6_side_reg),
        .out_vld  (m_vld),
        .residue  (m_res),
        .out_side (m_side)
    );

    // ---------------------------------------------------------------
    // stage 7: add the offset to the angle and wrap to [-pi, pi)
    logic                 s7_vld_reg;
    rot_side_t            s7_side_reg;
    logic signed [VW-1:0] s7_mag_reg;
    logic signed [ZW-1:0] s7_ang_reg;
    logic [31:0]          off_adj;
    logic signed [ZW-1:0] ang_sum;

    assign off_adj = (m_side.wneg && m_res != 32'd0) ? (rpvs_pkg::TWO_PI_U - m_res) : m_res;

    always_comb
    begin
        ang_sum = $signed(m_side.ang) + $signed({4'b0, off_adj});
        if (ang_sum >= rpvs_pkg::PI)
        begin
            ang_sum = ang_sum - rpvs_pkg::TWO_PI;
        end
        if (ang_sum >= rpvs_pkg::PI)
        begin
            ang_sum = ang_sum - rpvs_pkg::TWO_PI;
        end
        if (ang_sum < -rpvs_pkg::PI)
        begin
            ang_sum = ang_sum + rpvs_pkg::TWO_PI;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s7_vld_reg <= m_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s7_side_reg.region <= m_side.region;
            s7_mag_reg         <= $signed(m_side.mag);
            s7_ang_reg         <= ang_sum;
        end
    end

    // ---------------------------------------------------------------
    // back to rectangular form
    logic                 r_vld;
    logic signed [VW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    rot_side_t            r_side;

    rpvs_cordic #(
        .W      (VW),
        .STEPS  (CORDIC_STEPS),
        .VECTOR (1'b0),
        .SW     ($bits(rot_side_t))
    ) u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (s7_vld_reg),
        .in_x     (s7_mag_reg),
        .in_y     ('0),
        .in_z     (s7_ang_reg),
        .in_side  (s7_side_reg),
        .out_vld  (r_vld),
        .out_x    (r_x),
        .out_y    (r_y),
        .out_z    (r_z),
        .out_side (r_side)
    );

    // ---------------------------------------------------------------
    // output register: round off guard bits, saturate, pick pass-through
    function automatic logic [31:0] round_sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] s;
        s = (v + VW'(32768)) >>> 16;
        if (s > VW'(64'sd2147483647))
        begin
            return 32'h7fff_ffff;
        end
        else if (s < VW'(-64'sd2147483648))
        begin
            return 32'h8000_0000;
        end
        else
        begin
            return s[31:0];
        end
    endfunction

    logic [31:0]       out_real_reg, out_imag_reg;
    rpvs_pkg::region_t out_region_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_region_reg <= r_side.region;
            if (r_side.region == rpvs_pkg::REGION_BEFORE)
            begin
                out_real_reg <= ref_real_reg;
                out_imag_reg <= ref_imag_reg;
            end
            else
            begin
                out_real_reg <= round_sat(r_x);
                out_imag_reg <= round_sat(r_y);
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_imag_reg, out_real_reg};
    assign m_tuser  = out_region_reg;

endmodule

`default_nettype wire

// ===== design/rpvs_checker.sv =====
// Port-level checks for the ramped phasor voltage source, bound to the top level.
// Depends on rpvs_pkg for the region codes.
`default_nettype none

module rpvs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [47:0] cfg_data
);

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // region code is always one of the three defined values
    a_region: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == rpvs_pkg::REGION_BEFORE || m_tuser == rpvs_pkg::REGION_RAMP
                      || m_tuser == rpvs_pkg::REGION_AFTER))
        else $error("undefined region code");

    // input side never stalls while the output is empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // input stalls only because the output is held
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // configuration writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind ramped_phasor_voltage_source_unit rpvs_checker u_rpvs_checker (.*);

`default_nettype wire

// ===== tb/ramped_phasor_voltage_source_unit_test.sv =====
// Self-checking testbench for ramped_phasor_voltage_source_unit: directed and random
// sim_time streams under several register settings, checked against a bit-exact predictor.
// Depends on rpvs_pkg and the unit under test.
`default_nettype none

module ramped_phasor_voltage_source_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpvs_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        region_t     reg_id;
    } phasor_result_t;

    // Predicts the phasor for each sim_time and checks the results in order
    class phasor_scoreboard;
        phasor_result_t pending[$];
        bit [47:0] regs[7];
        int errors;
        int checked;
        longint atan_tab[30] = '{
            421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
            8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
            8, 4, 2, 1};

        function void set_reg(logic [2:0] idx, logic [47:0] data);
            if (idx <= REG_EXTRA_RATE)
                regs[idx] = {16'd0, data[31:0]};
            else if (idx <= REG_RAMP_LENGTH)
                regs[idx] = data;
        endfunction

        function longint sx(bit [47:0] v);
            return longint'(signed'(v[31:0]));
        endfunction

        function longint scale_inv_k(longint v);
            bit [63:0] u;
            longint r;
            u = (v < 0) ? -v : v;
            r = (u >> 32) * INV_K + (((u & 64'hFFFF_FFFF) * INV_K) >> 32);
            return (v < 0) ? -r : r;
        endfunction

        function void rotate(input longint xi, input longint yi, input longint zi,
                             output longint xo, output longint yo);
            longint x, y, z, t, dx, dy;
            x = xi; y = yi; z = zi;
            if (z > HALF_PI) begin
                t = x; x = -y; y = t; z -= HALF_PI;
            end
            else if (z < -HALF_PI) begin
                t = x; x = y; y = -t; z += HALF_PI;
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end
                else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            xo = scale_inv_k(x);
            yo = scale_inv_k(y);
        endfunction

        function void to_polar(input longint xi, input longint yi,
                               output longint mag, output longint ang);
            longint x, y, z, t, dx, dy;
            x = xi; y = yi; z = 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = HALF_PI;
                end
                else begin
                    t = x; x = -y; y = t; z = -HALF_PI;
                end
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
                else begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end
            end
            mag = scale_inv_k(x);
            ang = z;
        endfunction

        function longint frac_scale(longint s, bit [63:0] f);
            bit [63:0] u;
            longint r;
            u = ((s < 0) ? -s : s) * f;
            r = (u + 64'h8000_0000) >> 32;
            return (s < 0) ? -r : r;
        endfunction

        function logic [31:0] clip32(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        // note one accepted sim_time and queue its predicted phasor
        function void note_time(bit [47:0] t_in);
            phasor_result_t e;
            bit [63:0] t, ts, tr, rem, f, off, a;
            bit [127:0] prod;
            longint rr, ri, sr, si, w, px, py, fade, mag, ang, x, y, c, cy, tmp;
            t = t_in; ts = regs[REG_SWITCH_TIME]; tr = regs[REG_RAMP_LENGTH];
            rr = sx(regs[REG_REF_REAL]); ri = sx(regs[REG_REF_IMAG]);
            sr = sx(regs[REG_STEP_REAL]); si = sx(regs[REG_STEP_IMAG]);
            w = sx(regs[REG_EXTRA_RATE]);
            if (t < ts) begin
                e.re = clip32(rr); e.im = clip32(ri); e.reg_id = REGION_BEFORE;
                pending.push_back(e);
                return;
            end
            if (t < ts + tr) begin
                // restoring division gives the ramp fraction
                rem = t - ts; f = 0;
                for (int i = 0; i < 32; i++) begin
                    rem <<= 1; f <<= 1;
                    if (rem >= tr) begin
                        rem -= tr; f |= 1;
                    end
                end
                rotate(longint'(1) << 30, 0, longint'((64'(PI_U) * f) >> 32), c, cy);
                tmp = (longint'(1) << 30) - c;
                if (tmp < 0) tmp = 0;
                fade = (tmp + 1) >> 1;
                if (fade > (longint'(1) << 30)) fade = longint'(1) << 30;
                px = rr + frac_scale(sr, f);
                py = ri + frac_scale(si, f);
                e.reg_id = REGION_RAMP;
            end
            else begin
                fade = longint'(1) << 30;
                px = rr + sr;
                py = ri + si;
                e.reg_id = REGION_AFTER;
            end
            to_polar(px * 65536, py * 65536, mag, ang);
            // angle offset from the extra rate, reduced modulo two pi
            a = ((w < 0) ? -w : w) * fade;
            prod = 128'(a) * 128'(t);
            off = 64'(prod >> 49) % 64'(TWO_PI_U);
            if (w < 0 && off != 0) off = 64'(TWO_PI_U) - off;
            ang += longint'(off);
            if (ang >= PI) ang -= TWO_PI;
            if (ang >= PI) ang -= TWO_PI;
            if (ang < -PI) ang += TWO_PI;
            rotate(mag, 0, ang, x, y);
            e.re = clip32((x + 32768) >>> 16);
            e.im = clip32((y + 32768) >>> 16);
            pending.push_back(e);
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] user);
            phasor_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result data=%h region=%0d", $realtime, data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (data[31:0] !== e.re) begin
                $display("%0t: out_real expected %h actual %h", $realtime, e.re, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.im) begin
                $display("%0t: out_imag expected %h actual %h", $realtime, e.im, data[63:32]);
                errors++;
            end
            if (user !== e.reg_id) begin
                $display("%0t: region expected %0d actual %0d", $realtime, e.reg_id, user);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    phasor_scoreboard sb = new();
    bit  quiet = 0;
    int  sent = 0;
    bit [47:0] cur_ts, cur_tr;

    ramped_phasor_voltage_source_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // stall the output side in random bursts
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
        if (idx == REG_SWITCH_TIME) cur_ts = data;
        if (idx == REG_RAMP_LENGTH) cur_tr = data;
    endtask

    // write all registers; high bits above 32 are random noise for the narrow ones but the imaginary step
    task automatic load_setting(logic [31:0] rr, logic [31:0] ri, logic [31:0] sr,
                                logic [31:0] si, logic [31:0] w,
                                logic [47:0] ts, logic [47:0] tr);
        logic [15:0] junk;
        junk = $urandom;
        write_reg(REG_REF_REAL, {junk, rr});
        write_reg(REG_REF_IMAG, {~junk, ri});
        write_reg(REG_STEP_REAL, {junk, sr});
        write_reg(REG_STEP_IMAG, {16'd0, si});
        write_reg(REG_EXTRA_RATE, {~junk, w});
        write_reg(REG_SWITCH_TIME, ts);
        write_reg(REG_RAMP_LENGTH, tr);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_time(logic [47:0] t);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= t;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_time(t);
        sent++;
    endtask

    function automatic logic [47:0] pick_time();
        logic [47:0] r48;
        r48 = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return r48;
            1: return cur_ts + ((cur_tr == 0) ? 48'd0 : r48 % cur_tr);
            2: return cur_ts + $urandom_range(0, 2) - 1;
            3: return cur_ts + cur_tr + $urandom_range(0, 2) - 1;
            default: return (cur_ts == 0) ? r48 : r48 % cur_ts;
        endcase
    endfunction

    // let the pipe drain before the next register change
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        repeat (n) send_time(pick_time());
        drain();
    endtask

    function automatic logic [47:0] rnd48();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        cur_ts = 0;
        cur_tr = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset setting: zero phasor, all times past the instant switch
        send_time(48'd0);
        send_time(48'hFFFF_FFFF_FFFF);
        send_time(48'h0000_8000_0000);
        drain();

        // extremes of amplitude and rate, long ramp from a small start
        load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 48'd100, 48'hFFFF_FFFF_FFFF);
        send_time(48'd0);
        send_time(48'd99);
        send_time(48'd100);
        send_time(48'd101);
        send_time(48'h8000_0000_0000);
        send_time(48'hFFFF_FFFF_FFFF);
        drain();

        // negative rate, ramp starts at the very end of the time range
        load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000,
                     32'h8000_0000, 48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF);
        send_time(48'hFFFF_FFFF_FFFD);
        send_time(48'hFFFF_FFFF_FFFE);
        send_time(48'hFFFF_FFFF_FFFF);
        send_time(48'd0);
        drain();

        // zero-length ramp and a one-tick ramp; an unused index must be ignored
        load_setting(32'h0001_0000, 32'hFFFF_0000, 32'h0002_3000, 32'h0000_0000,
                     32'h0001_0000, 48'h0001_0000_0000, 48'd0);
        write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
        cfg_valid <= 0;
        send_time(48'h0000_FFFF_FFFF);
        send_time(48'h0001_0000_0000);
        send_time(48'h0001_0000_0001);
        drain();
        write_reg(REG_RAMP_LENGTH, 48'd1);
        cfg_valid <= 0;
        send_time(48'h0001_0000_0000);
        send_time(48'h0001_0000_0001);
        drain();

        // random settings, moderate and full range
        for (int p = 0; p < 10; p++)
        begin
            if (p % 2 == 0)
                load_setting($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                             $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                             $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                             $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                             $urandom, {16'd0, $urandom} % 48'h0020_0000_0000,
                             {16'd0, $urandom} % 48'h0010_0000_0000 + 1);
            else
                load_setting($urandom, $urandom, $urandom, $urandom, $urandom,
                             rnd48(), rnd48() >> $urandom_range(0, 40));
            if (p == 9) quiet = 1;
            random_phase(p == 9 ? 200 : 100);
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d sim_time samples, %0d results checked, across 15 settings.",
                 sent, sb.checked);
        $display("Settings spanned zero, one-tick and full-range ramps and extreme rates.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/rpvs_pkg.sv
design/rpvs_div.sv
design/rpvs_mod.sv
design/rpvs_cordic.sv
design/ramped_phasor_voltage_source_unit.sv
design/rpvs_checker.sv
tb/ramped_phasor_voltage_source_unit_test.sv
